### hdl/fbmwl_pkg.sv
`timescale 1ns / 1ps

package fbmwl_pkg;

    localparam int LB_NUM  = 32;
    localparam int LB_W    = 5;
    localparam int CNT_W   = 16;
    localparam int PHYS_OW = 5;

    localparam int DEF_NUM_BLOCKS = 32;

    localparam logic [CNT_W-1:0] DEF_THRESHOLD = 16'd5;
    localparam logic [CNT_W-1:0] CNT_MAX       = 16'hFFFF;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_ERASE = 2'd2;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_COPY  = 3'd3;
    localparam logic [2:0] CMD_ERASE = 3'd4;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_DISP   = 10'b00_0000_0100,
        S_WIPE   = 10'b00_0000_1000,
        S_SCAN   = 10'b00_0001_0000,
        S_SLAST  = 10'b00_0010_0000,
        S_DECIDE = 10'b00_0100_0000,
        S_REMAP  = 10'b00_1000_0000,
        S_FERASE = 10'b01_0000_0000,
        S_FWRITE = 10'b10_0000_0000
    } t_state;

    function automatic logic [CNT_W-1:0] f_sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

### hdl/flash_block_map_wear_leveling_unit.sv
`timescale 1ns / 1ps
// Read, and erase of an unmapped block: one output word per request; erase of a mapped block:
// one ERASE word. Write: a scan of all NUM_BLOCKS count words, after an ERASE of the old block
// when one is mapped, then a WRITE (NONE with status if none is writable), or a COPY, map search,
// ERASE and WRITE when a cold-data swap runs; output stalls hold every step that emits a word.
// Reset: synchronous, active low; after it a clearing pass over all NUM_BLOCKS words
// initialises the count table while requests stall.
module flash_block_map_wear_leveling_unit
    import fbmwl_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [LB_W-1:0]    i_logical_block,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_command,
    output logic [PHYS_OW-1:0] o_phys_block,
    output logic [PHYS_OW-1:0] o_copy_source,
    output logic               o_status,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_wdata
);

    localparam int PW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    function automatic logic [PHYS_OW-1:0] f_pout(input logic [PW-1:0] idx);
        logic [PW+PHYS_OW-1:0] t;
        t = {{PHYS_OW{1'b0}}, idx};
        return t[PHYS_OW-1:0];
    endfunction

    // count table: {writable, erase count}
    logic [CNT_W:0]    r_mem [NUM_BLOCKS];
    logic [CNT_W:0]    r_rd_data;
    logic              mem_we;
    logic [PW-1:0]     mem_waddr, mem_raddr;
    logic [CNT_W:0]    mem_wdata;

    logic [PW-1:0]     r_map [LB_NUM];
    logic [LB_NUM-1:0] r_mvalid;
    logic              map_we, map_wvalid;
    logic [LB_W-1:0]   map_ra, map_wa;
    logic [PW-1:0]     map_wdata;
    logic              mv;
    logic [PW-1:0]     mp;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_thr;
    logic [1:0]        r_kind, n_kind;
    logic [LB_W-1:0]   r_lb, n_lb;
    logic [PW-1:0]     r_p, n_p;
    logic [PW-1:0]     r_addr, n_addr;
    logic [LB_W-1:0]   r_mi, n_mi;
    logic              r_sv, n_sv;
    logic [PW-1:0]     r_sidx, n_sidx;
    logic              r_hf, n_hf, r_hu, n_hu;
    logic [PW-1:0]     r_fidx, n_fidx, r_uidx, n_uidx;
    logic [CNT_W-1:0]  r_fcnt, n_fcnt, r_ucnt, n_ucnt;

    logic               r_o_valid, n_o_valid;
    logic [2:0]         r_o_cmd, n_o_cmd;
    logic [PHYS_OW-1:0] r_o_phys, n_o_phys, r_o_src, n_o_src;
    logic               r_o_status, n_o_status, r_o_last, n_o_last;

    logic              out_free;
    logic              rd_wr;
    logic [CNT_W-1:0]  rd_cnt, cmp_ref;
    logic              cmp_lt;

    assign out_free  = !r_o_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign mv = r_mvalid[map_ra];
    assign mp = r_map[map_ra];

    assign rd_wr   = r_rd_data[CNT_W];
    assign rd_cnt  = r_rd_data[CNT_W-1:0];
    assign cmp_ref = rd_wr ? r_fcnt : r_ucnt;
    assign cmp_lt  = rd_cnt < cmp_ref;

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_lb       = r_lb;
        n_p        = r_p;
        n_addr     = r_addr;
        n_mi       = r_mi;
        n_sv       = 1'b0;
        n_sidx     = r_sidx;
        n_hf       = r_hf;
        n_hu       = r_hu;
        n_fidx     = r_fidx;
        n_uidx     = r_uidx;
        n_fcnt     = r_fcnt;
        n_ucnt     = r_ucnt;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_cmd    = r_o_cmd;
        n_o_phys   = r_o_phys;
        n_o_src    = r_o_src;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        mem_we     = 1'b0;
        mem_waddr  = r_p;
        mem_wdata  = r_rd_data;
        mem_raddr  = r_p;
        map_ra     = r_lb;
        map_we     = 1'b0;
        map_wa     = r_lb;
        map_wvalid = 1'b0;
        map_wdata  = r_fidx;

        // running minima over the scanned words
        if (r_sv) begin
            if (rd_wr && (!r_hf || cmp_lt)) begin
                n_hf   = 1'b1;
                n_fidx = r_sidx;
                n_fcnt = rd_cnt;
            end
            if (!rd_wr && (!r_hu || cmp_lt)) begin
                n_hu   = 1'b1;
                n_uidx = r_sidx;
                n_ucnt = rd_cnt;
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = {1'b1, {CNT_W{1'b0}}};
                if (r_addr == PW'(NUM_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_lb    = i_logical_block;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                mem_raddr = mp;
                n_p       = mp;
                n_addr    = '0;
                n_hf      = 1'b0;
                n_hu      = 1'b0;
                priority if (r_kind == KIND_READ) begin
                    if (out_free) begin
                        n_o_valid  = 1'b1;
                        n_o_cmd    = mv ? CMD_READ : CMD_NONE;
                        n_o_phys   = mv ? f_pout(mp) : '0;
                        n_o_src    = '0;
                        n_o_status = !mv;
                        n_o_last   = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (r_kind == KIND_ERASE) begin
                    if (mv) begin
                        n_state = S_WIPE;
                    end else if (out_free) begin
                        n_o_valid  = 1'b1;
                        n_o_cmd    = CMD_NONE;
                        n_o_phys   = '0;
                        n_o_src    = '0;
                        n_o_status = 1'b1;
                        n_o_last   = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (r_kind == KIND_WRITE) begin
                    n_state = mv ? S_WIPE : S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WIPE: begin
                if (out_free) begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_p;
                    mem_wdata  = {1'b1, f_sat_inc(rd_cnt)};
                    n_o_valid  = 1'b1;
                    n_o_cmd    = CMD_ERASE;
                    n_o_phys   = f_pout(r_p);
                    n_o_src    = '0;
                    n_o_status = 1'b0;
                    n_o_last   = (r_kind == KIND_ERASE);
                    if (r_kind == KIND_ERASE) begin
                        map_we     = 1'b1;
                        map_wdata  = '0;
                        map_wvalid = 1'b0;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                mem_raddr = r_addr;
                n_sv      = 1'b1;
                n_sidx    = r_addr;
                if (r_addr == PW'(NUM_BLOCKS - 1)) begin
                    n_state = S_SLAST;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_SLAST: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_src    = '0;
                    n_o_status = 1'b0;
                    n_o_last   = 1'b1;
                    priority if (!r_hf) begin
                        n_o_cmd    = CMD_NONE;
                        n_o_phys   = '0;
                        n_o_status = 1'b1;
                        map_we     = 1'b1;
                        map_wdata  = '0;
                        n_state    = S_IDLE;
                    end else if (r_fcnt >= r_thr && r_hu) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_fidx;
                        mem_wdata = {1'b0, r_fcnt};
                        n_o_cmd   = CMD_COPY;
                        n_o_phys  = f_pout(r_fidx);
                        n_o_src   = f_pout(r_uidx);
                        n_o_last  = 1'b0;
                        n_mi      = '0;
                        n_state   = S_REMAP;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = r_fidx;
                        mem_wdata  = {1'b0, r_fcnt};
                        map_we     = 1'b1;
                        map_wvalid = 1'b1;
                        n_o_cmd    = CMD_WRITE;
                        n_o_phys   = f_pout(r_fidx);
                        n_state    = S_IDLE;
                    end
                end
            end
            S_REMAP: begin
                map_ra = r_mi;
                if (mv && mp == r_uidx) begin
                    map_we     = 1'b1;
                    map_wa     = r_mi;
                    map_wvalid = 1'b1;
                    n_state    = S_FERASE;
                end else if (r_mi == LB_W'(LB_NUM - 1)) begin
                    n_state = S_FERASE;
                end else begin
                    n_mi = r_mi + 1'b1;
                end
            end
            S_FERASE: begin
                if (out_free) begin
                    // freed block is erased then written: store the final word at once
                    mem_we     = 1'b1;
                    mem_waddr  = r_uidx;
                    mem_wdata  = {1'b0, f_sat_inc(r_ucnt)};
                    n_o_valid  = 1'b1;
                    n_o_cmd    = CMD_ERASE;
                    n_o_phys   = f_pout(r_uidx);
                    n_o_src    = '0;
                    n_o_status = 1'b0;
                    n_o_last   = 1'b0;
                    n_state    = S_FWRITE;
                end
            end
            S_FWRITE: begin
                if (out_free) begin
                    map_we     = 1'b1;
                    map_wvalid = 1'b1;
                    map_wdata  = r_uidx;
                    n_o_valid  = 1'b1;
                    n_o_cmd    = CMD_WRITE;
                    n_o_phys   = f_pout(r_uidx);
                    n_o_src    = '0;
                    n_o_status = 1'b0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= '0;
        end else if (map_we) begin
            r_mvalid[map_wa] <= map_wvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_wa] <= map_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_sv      <= 1'b0;
            r_o_valid <= 1'b0;
            r_thr     <= DEF_THRESHOLD;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_sv      <= n_sv;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_lb       <= n_lb;
        r_p        <= n_p;
        r_mi       <= n_mi;
        r_sidx     <= n_sidx;
        r_hf       <= n_hf;
        r_hu       <= n_hu;
        r_fidx     <= n_fidx;
        r_uidx     <= n_uidx;
        r_fcnt     <= n_fcnt;
        r_ucnt     <= n_ucnt;
        r_o_cmd    <= n_o_cmd;
        r_o_phys   <= n_o_phys;
        r_o_src    <= n_o_src;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid   = r_o_valid;
    assign o_command     = r_o_cmd;
    assign o_phys_block  = r_o_phys;
    assign o_copy_source = r_o_src;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while busy");

    a_status_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_command == CMD_NONE && o_last))
        else $error("unmapped status on a real command");

    a_swap_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMAP) |-> (r_fidx != r_uidx && r_hf && r_hu))
        else $error("swap source equals destination");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_out_valid && o_in_stall))
        else $error("activity during clearing pass");

endmodule
